/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked at every rising edge
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/hiec_pkg.sv */
// ----------------------------------------------------------------------------
// hiec_pkg
// types and constants shared by the hex image extent and checksum unit
// ----------------------------------------------------------------------------
package hiec_pkg;

	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	localparam logic OP_HEADER = 1'b0;
	localparam logic OP_BYTE   = 1'b1;

	localparam logic [2:0] KIND_DATA    = 3'd0;
	localparam logic [2:0] KIND_EOF     = 3'd1;
	localparam logic [2:0] KIND_EXT_SEG = 3'd2;
	localparam logic [2:0] KIND_EXT_LIN = 3'd4;

	localparam logic [7:0] INDEX_MAX = 8'hFF;

	typedef struct packed {
		logic        operation;
		logic [2:0]  record_type;
		logic [15:0] record_address;
		logic [7:0]  record_length;
		logic [7:0]  data_byte;
	} hiec_item_t;

	typedef struct packed {
		logic [31:0] start_address;
		logic [31:0] image_size;
		logic [31:0] image_checksum;
	} hiec_result_t;

	// term for the byte sum: a data byte, or an address gap to be scaled by 0xff
	typedef struct packed {
		logic [31:0] value;
		logic        gap;
	} hiec_pend_t;

endpackage

/* rtl/core/hiec_addr_track.sv */
// ----------------------------------------------------------------------------
// hiec_addr_track
// record decode, base address, image extent and byte sum terms
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hiec_addr_track
	import hiec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  hiec_item_t  item,
	output hiec_pend_t  pend,
	output logic        eof,
	output logic [31:0] start_address,
	output logic [31:0] image_size
);

	logic [31:0] base_q;
	logic [31:0] expected_q;
	logic [31:0] end_q;
	logic [31:0] first_q;
	logic [2:0]  kind_q;
	logic [7:0]  index_q;
	logic [7:0]  high_q;

	logic [31:0] cur;
	logic [31:0] stop;
	logic        is_hdr;
	logic        ext_kind;

	always_comb begin
		cur      = base_q + {16'h0000, item.record_address};
		stop     = cur + {24'h00_0000, item.record_length};
		is_hdr   = fire && (item.operation == OP_HEADER);
		eof      = is_hdr && (item.record_type == KIND_EOF);
		ext_kind = (kind_q == KIND_EXT_SEG) || (kind_q == KIND_EXT_LIN);
		pend     = '0;
		if (fire && (item.operation == OP_BYTE) && (kind_q == KIND_DATA)) begin
			pend.value = {24'h00_0000, item.data_byte};
			pend.gap   = 1'b0;
		end else if (is_hdr && (item.record_type == KIND_DATA) &&
				(expected_q != ALL_ONES)) begin
			pend.value = cur - expected_q;
			pend.gap   = 1'b1;
		end
		start_address = first_q;
		image_size    = end_q - first_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			expected_q <= ALL_ONES;
			end_q      <= '0;
			first_q    <= ALL_ONES;
			kind_q     <= KIND_DATA;
			index_q    <= '0;
			high_q     <= '0;
		end else if (fire) begin
			if (item.operation == OP_BYTE) begin
				if (ext_kind) begin
					if (index_q == 8'd0) begin
						high_q <= item.data_byte;
					end else if (index_q == 8'd1) begin
						if (kind_q == KIND_EXT_SEG) begin
							base_q <= {12'h000, high_q, item.data_byte, 4'h0};
						end else begin
							base_q <= {high_q, item.data_byte, 16'h0000};
						end
					end
				end
				if (index_q != INDEX_MAX) begin
					index_q <= index_q + 8'd1;
				end
			end else if (item.record_type == KIND_EOF) begin
				base_q     <= '0;
				expected_q <= ALL_ONES;
				end_q      <= '0;
				first_q    <= ALL_ONES;
				kind_q     <= KIND_DATA;
				index_q    <= '0;
				high_q     <= '0;
			end else begin
				kind_q  <= item.record_type;
				index_q <= '0;
				if (item.record_type == KIND_DATA) begin
					if (first_q == ALL_ONES) begin
						first_q <= cur;
					end
					end_q      <= stop;
					expected_q <= stop;
				end
			end
		end
	end

	`ASSERT_NEXT(a_eof_clears_extent, eof,
		(first_q == ALL_ONES) && (expected_q == ALL_ONES) && (base_q == 32'h0),
		"extent state not cleared after end of file")

endmodule

/* rtl/core/hiec_sum_acc.sv */
// ----------------------------------------------------------------------------
// hiec_sum_acc
// negated byte sum with gap fill, one term per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hiec_sum_acc
	import hiec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clear,
	input  hiec_pend_t  pend,
	output logic [31:0] checksum
);

	hiec_pend_t  pend_s2;
	logic [31:0] acc_q;
	logic [31:0] term;

	// gap times 0xff as a shift and subtract
	always_comb begin
		if (pend_s2.gap) begin
			term = {pend_s2.value[23:0], 8'h00} - pend_s2.value;
		end else begin
			term = pend_s2.value;
		end
		checksum = acc_q - term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= '0;
			acc_q   <= '0;
		end else begin
			pend_s2 <= pend;
			if (clear) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_q - term;
			end
		end
	end

	`ASSERT_NEXT(a_clear_zero_sum, clear, checksum == 32'h0,
		"checksum not zero after end of file")

endmodule

/* rtl/core/hex_image_extent_checksum_unit.sv */
// ----------------------------------------------------------------------------
// hex_image_extent_checksum_unit
// image start, size and checksum over a stream of hex records
// ----------------------------------------------------------------------------
// Input channel item_valid / item_ready / item carries one beat per record
// header or data byte. A header of type end of file produces one beat on the
// result channel result_valid / result_ready / result; no other beat does.
// Every beat is registered, then decoded against the address state, so one
// input beat is taken per clock while item_ready is high. Byte and gap-fill
// terms pass a register, then are folded into the checksum and the result.
// An end-of-file beat passes the decode register, then the result register.
// While a result waits on a stalled receiver, input beats keep flowing until
// the next end-of-file beat reaches the decode register; it is held there
// until the result register frees, and item_ready drops meanwhile.
// Reset clears the address and sum state and the valid bits of both registers;
// no clearing pass is needed, so the first beat can be taken right after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hex_image_extent_checksum_unit
	import hiec_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  hiec_item_t   item,
	output logic         result_valid,
	input  logic         result_ready,
	output hiec_result_t result
);

	logic         valid_s1;
	hiec_item_t   item_s1;
	logic         eof_s1;
	logic         advance;
	logic         eof_fire;
	hiec_pend_t   pend;
	logic [31:0]  start_address;
	logic [31:0]  image_size;
	logic [31:0]  checksum;
	logic         result_valid_q;
	hiec_result_t result_q;

	assign eof_s1     = (item_s1.operation == OP_HEADER) && (item_s1.record_type == KIND_EOF);
	assign advance    = valid_s1 && (!eof_s1 || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	hiec_addr_track u_addr_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (advance),
		.item          (item_s1),
		.pend          (pend),
		.eof           (eof_fire),
		.start_address (start_address),
		.image_size    (image_size)
	);

	hiec_sum_acc u_sum_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (eof_fire),
		.pend     (pend),
		.checksum (checksum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (eof_fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eof_fire) begin
			result_q.start_address  <= start_address;
			result_q.image_size     <= image_size;
			result_q.image_checksum <= checksum;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ASSERT_NEXT(a_eof_gives_result, eof_fire, result_valid_q,
		"end of file beat left no result")
	`ASSERT_CLK(a_stall_only_on_eof,
		item_ready || (valid_s1 && eof_s1 && result_valid_q && !result_ready),
		"input stalled without a pending end of file")

endmodule

/* tb/hiec_image_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hiec_image_checker
// Watches both channels of the hex image extent and checksum unit. Every
// accepted input beat is folded into a local copy of the address and sum
// state; an end-of-file header queues the image start, size and checksum
// that the unit must return. Result beats are compared field by field with
// the oldest queued image. The mismatch count and the number of images still
// outstanding are handed to the testbench top.
// ----------------------------------------------------------------------------
module hiec_image_checker
	import hiec_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	input  logic         item_ready,
	input  hiec_item_t   item,
	input  logic         result_valid,
	input  logic         result_ready,
	input  hiec_result_t result,
	output int           mismatches,
	output int           images_due,
	output int           images_seen
);

	logic [31:0]  base_addr;
	logic [31:0]  next_addr;
	logic [31:0]  end_addr;
	logic [31:0]  first_addr;
	logic [31:0]  byte_sum;
	logic [2:0]   record_kind;
	logic [7:0]   byte_count;
	logic [7:0]   held_byte;
	hiec_result_t expected_images[$];
	hiec_result_t want;

	task automatic clear_image();
		base_addr   = '0;
		next_addr   = ALL_ONES;
		end_addr    = '0;
		first_addr  = ALL_ONES;
		byte_sum    = '0;
		record_kind = KIND_DATA;
		byte_count  = '0;
		held_byte   = '0;
	endtask

	task automatic compare_field(input string field, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (exp_val !== got_val) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s of image %0d: expected %08h, got %08h",
					field, images_seen, exp_val, got_val);
		end
	endtask

	task automatic fold_beat_into_image(input hiec_item_t b);
		logic [31:0]  here;
		logic [15:0]  word;
		hiec_result_t image;
		if (b.operation == OP_BYTE) begin
			if (record_kind == KIND_DATA) begin
				byte_sum += {24'h0, b.data_byte};
			end else if (record_kind == KIND_EXT_SEG || record_kind == KIND_EXT_LIN) begin
				if (byte_count == 8'd0) begin
					held_byte = b.data_byte;
				end else if (byte_count == 8'd1) begin
					word = {held_byte, b.data_byte};
					base_addr = (record_kind == KIND_EXT_SEG) ? {12'h000, word, 4'h0}
						: {word, 16'h0000};
				end
			end
			if (byte_count != INDEX_MAX)
				byte_count++;
		end else if (b.record_type == KIND_EOF) begin
			image.start_address  = first_addr;
			image.image_size     = end_addr - first_addr;
			image.image_checksum = 32'h0 - byte_sum;
			expected_images.push_back(image);
			clear_image();
		end else begin
			record_kind = b.record_type;
			byte_count  = 8'd0;
			if (b.record_type == KIND_DATA) begin
				here = base_addr + {16'h0, b.record_address};
				if (first_addr == ALL_ONES)
					first_addr = here;
				end_addr = here + {24'h0, b.record_length};
				// gap since the last record counts as 0xff fill
				if (next_addr != ALL_ONES && here != next_addr)
					byte_sum += 32'hFF * (here - next_addr);
				next_addr = end_addr;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_image();
			expected_images.delete();
			mismatches  = 0;
			images_due  = 0;
			images_seen = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_images.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result beat with no image pending: %08h %08h %08h",
							result.start_address, result.image_size, result.image_checksum);
				end else begin
					want = expected_images.pop_front();
					compare_field("start_address", want.start_address, result.start_address);
					compare_field("image_size", want.image_size, result.image_size);
					compare_field("image_checksum", want.image_checksum, result.image_checksum);
				end
				images_seen++;
			end
			if (item_valid && item_ready)
				fold_beat_into_image(item);
			images_due = expected_images.size();
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives record headers and data bytes into the hex image extent and
// checksum unit: a directed opening over address extremes, address records
// of three lengths, start and unused record types, stray bytes and empty
// images, then random images made mostly of well-formed records with some
// noise. The sender idles in bursts, the receiver stalls on its own pattern,
// and a checker beside the unit predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
	import hiec_pkg::*;

	localparam logic [2:0] KIND_START_SEG = 3'd3;
	localparam logic [2:0] KIND_START_LIN = 3'd5;
	localparam logic [2:0] KIND_SPARE_6   = 3'd6;
	localparam logic [2:0] KIND_SPARE_7   = 3'd7;
	localparam int CYCLE_LIMIT = 400000;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         item_valid;
	logic         item_ready;
	hiec_item_t   item;
	logic         result_valid;
	logic         result_ready = 1'b0;
	hiec_result_t result;

	int mismatches;
	int images_due;
	int images_seen;
	int beats_sent = 0;
	int eofs_sent = 0;
	int burst_left = 0;
	int ready_hold = 0;
	int cycle_count = 0;
	logic [15:0] next_offset = '0;

	hex_image_extent_checksum_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	hiec_image_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.mismatches   (mismatches),
		.images_due   (images_due),
		.images_seen  (images_seen)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb: failure");
			$finish;
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (ready_hold == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					result_ready <= 1'b1;
					ready_hold = $urandom_range(0, 24);
				end
				6, 7, 8: begin
					result_ready <= 1'b0;
					ready_hold = $urandom_range(0, 5);
				end
				default: begin
					result_ready <= 1'b0;
					ready_hold = $urandom_range(12, 30);
				end
			endcase
		end else begin
			ready_hold--;
		end
	end

	task automatic send_beat(input hiec_item_t beat);
		if (burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 24);
		end
		item       <= beat;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		burst_left--;
		beats_sent++;
		if (beat.operation == OP_HEADER && beat.record_type == KIND_EOF)
			eofs_sent++;
	endtask

	task automatic send_header(input logic [2:0] kind, input logic [15:0] addr,
			input logic [7:0] len);
		hiec_item_t beat;
		beat.operation      = OP_HEADER;
		beat.record_type    = kind;
		beat.record_address = addr;
		beat.record_length  = len;
		beat.data_byte      = 8'($urandom);
		send_beat(beat);
	endtask

	task automatic send_byte(input logic [7:0] value);
		hiec_item_t beat;
		beat.operation      = OP_BYTE;
		beat.record_type    = 3'($urandom);
		beat.record_address = 16'($urandom);
		beat.record_length  = 8'($urandom);
		beat.data_byte      = value;
		send_beat(beat);
	endtask

	task automatic send_bytes(input int count);
		repeat (count) send_byte(8'($urandom));
	endtask

	task automatic send_random_image(input bit with_long_record);
		int records;
		int pick;
		int len;
		int count;
		logic [15:0] addr;
		logic [63:0] noise;
		records = $urandom_range(0, 6);
		// long address record runs the byte counter into saturation
		if (with_long_record) begin
			send_header($urandom_range(0, 1) ? KIND_EXT_SEG : KIND_EXT_LIN, 16'($urandom), 8'd2);
			send_bytes($urandom_range(256, 259));
		end
		for (int r = 0; r < records; r++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
				addr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : next_offset;
				count = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len + 3) : len;
				send_header(KIND_DATA, addr, 8'(len));
				send_bytes(count);
				next_offset = addr + 16'(len);
			end else if (pick < 66) begin
				send_header($urandom_range(0, 1) ? KIND_EXT_SEG : KIND_EXT_LIN,
					16'($urandom), 8'($urandom));
				send_bytes(($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : 2);
			end else if (pick < 76) begin
				send_header($urandom_range(0, 1) ? KIND_START_SEG : KIND_START_LIN,
					16'($urandom), 8'($urandom));
				send_bytes($urandom_range(0, 4));
			end else if (pick < 82) begin
				send_header($urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7,
					16'($urandom), 8'($urandom));
				send_bytes($urandom_range(0, 3));
			end else if (pick < 90) begin
				noise = {$urandom, $urandom};
				send_beat(noise[35:0]);
			end else begin
				send_bytes($urandom_range(1, 3));
			end
		end
		send_header(KIND_EOF, 16'($urandom), 8'($urandom));
	endtask

	initial begin
		int image_no;
		int wait_cycles;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// stray bytes straight after reset, then an empty image
		send_byte(8'h00);
		send_byte(8'hFF);
		send_header(KIND_EOF, 16'hFFFF, 8'hFF);
		// first data lands on all ones and does not fix the start
		send_header(KIND_EXT_LIN, 16'h0000, 8'd2);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_header(KIND_DATA, 16'hFFFF, 8'd1);
		send_byte(8'hAB);
		// wide gap, fewer bytes than the length says
		send_header(KIND_DATA, 16'h0000, 8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		// address record too short, then one with a spare byte
		send_header(KIND_EXT_SEG, 16'hFFFF, 8'd1);
		send_byte(8'h12);
		send_header(KIND_EXT_SEG, 16'h0000, 8'd3);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		// start records and unused types are ignored
		send_header(KIND_START_SEG, 16'h1234, 8'd4);
		send_byte(8'h55);
		send_header(KIND_START_LIN, 16'hFFFF, 8'd4);
		send_header(KIND_SPARE_6, 16'h8000, 8'd1);
		send_byte(8'hAA);
		send_header(KIND_SPARE_7, 16'h0001, 8'h80);
		send_header(KIND_DATA, 16'h0010, 8'd0);
		send_header(KIND_EOF, 16'h0000, 8'h00);
		send_byte(8'h7F);

		image_no = 0;
		while (beats_sent < 1100) begin
			send_random_image(image_no == 3 || $urandom_range(0, 39) == 0);
			image_no++;
		end
		item_valid <= 1'b0;

		wait_cycles = 0;
		do begin
			@(posedge clk);
			wait_cycles++;
		end while (images_due != 0 && wait_cycles < 4000);
		repeat (8) @(posedge clk);

		if (images_due != 0)
			$display("%0d images never returned", images_due);
		$display("summary: %0d beats over %0d images, %0d results checked, %0d mismatches",
			beats_sent, eofs_sent, images_seen, mismatches);
		$display("summary: %0d cycles with random sender gaps and receiver stalls",
			cycle_count);
		if (mismatches == 0 && images_due == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
